[design/smig_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smig_pkg
// Shared types and constants of the sphere mesh index generator.
// ----------------------------------------------------------------------------
package smig_pkg;

	// configuration port
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SLICE_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STACK_COUNT = 1'd1;

	// register reset values
	localparam int SLICE_RESET = 16;
	localparam int STACK_RESET = 8;

	// emitted index width
	localparam int IDX_W = 17;

	// command queue depth between sequencer and output stage
	localparam int QUEUE_DEPTH = 2;

	typedef logic [IDX_W-1:0] idx_t;

	// mesh part tags, also used as sequencer phases
	typedef enum logic [1:0] {
		PART_NORTH  = 2'd0,
		PART_BODY   = 2'd1,
		PART_MARKER = 2'd2,
		PART_SOUTH  = 2'd3
	} part_t;

	// one classified index: the output stage adds base and offset
	typedef struct packed {
		idx_t  base;
		idx_t  offs;
		part_t part;
		logic  last;
	} cmd_t;

endpackage

[design/smig_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smig_if
// Valid/ready channels of the sphere mesh index generator.
// ----------------------------------------------------------------------------
interface smig_in_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink   (input valid, input restart, output ready);
endinterface

interface smig_out_if;
	logic                      valid;
	logic                      ready;
	logic [smig_pkg::IDX_W-1:0] vertex_index;
	logic [1:0]                mesh_part;
	logic                      last;

	modport source (output valid, output vertex_index, output mesh_part, output last,
		input ready);
	modport sink   (input valid, input vertex_index, input mesh_part, input last,
		output ready);
endinterface

[design/smig_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smig_front
// Sequencer: holds the settings and the walk counters, accepts advance
// requests and turns each into one index command for the queue.
// ----------------------------------------------------------------------------
module smig_front #(
	parameter int MAX_SLICES = 256,
	parameter int MAX_STACKS = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [smig_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [smig_pkg::CFG_W-1:0]     cfg_data,
	smig_in_if.sink                       in_ch,
	input  logic                          push_ready,
	output logic                          push_valid,
	output smig_pkg::cmd_t                push_cmd
);
	import smig_pkg::*;

	localparam int SW = $clog2(MAX_SLICES + 1);
	localparam int TW = $clog2(MAX_STACKS + 1);

	logic [SW-1:0] slice_q;
	logic [TW-1:0] stack_q;
	idx_t          marker_q;

	part_t         phase_q, e_phase, n_phase;
	logic [TW-1:0] stack_cnt_q, e_stack, n_stack;
	logic [SW-1:0] slice_cnt_q, e_slice, n_slice;
	logic [1:0]    corner_q, e_corner, n_corner;
	idx_t          row_base_q, e_row_base, n_row_base;

	idx_t          s_ext, s1, j_ext;
	logic          take;
	logic [SW-1:0] new_slice;
	logic [TW-1:0] new_stack;
	logic [SW:0]   slice_inc;
	logic [TW+1:0] stack_inc3;

	// transfer handshake
	assign in_ch.ready = push_ready;
	assign push_valid  = in_ch.valid;
	assign take        = in_ch.valid && push_ready;

	// clamp of the written settings
	always_comb begin
		new_slice = slice_q;
		new_stack = stack_q;
		if (cfg_wr_en && cfg_index == REG_SLICE_COUNT) begin
			if (int'(cfg_data) < 3)
				new_slice = SW'(3);
			else if (int'(cfg_data) > MAX_SLICES)
				new_slice = SW'(MAX_SLICES);
			else
				new_slice = SW'(cfg_data);
		end
		if (cfg_wr_en && cfg_index == REG_STACK_COUNT) begin
			if (int'(cfg_data) < 2)
				new_stack = TW'(2);
			else if (int'(cfg_data) > MAX_STACKS)
				new_stack = TW'(MAX_STACKS);
			else
				new_stack = TW'(cfg_data);
		end
	end

	// state the request works from: a restart begins the walk anew
	assign s_ext = IDX_W'(slice_q);
	assign s1    = s_ext + IDX_W'(1);

	always_comb begin
		if (in_ch.restart) begin
			e_phase    = PART_NORTH;
			e_stack    = '0;
			e_slice    = '0;
			e_corner   = 2'd0;
			e_row_base = s1;
		end else begin
			e_phase    = phase_q;
			e_stack    = stack_cnt_q;
			e_slice    = slice_cnt_q;
			e_corner   = corner_q;
			e_row_base = row_base_q;
		end
	end

	assign j_ext      = IDX_W'(e_slice);
	assign slice_inc  = (SW + 1)'(e_slice) + (SW + 1)'(1);
	assign stack_inc3 = (TW + 2)'(e_stack) + (TW + 2)'(3);

	// classify the index and step the counters
	always_comb begin
		push_cmd.base = '0;
		push_cmd.offs = j_ext;
		push_cmd.part = e_phase;
		push_cmd.last = 1'b0;
		n_phase    = e_phase;
		n_stack    = e_stack;
		n_slice    = e_slice;
		n_corner   = e_corner;
		n_row_base = e_row_base;
		case (e_phase)
			PART_BODY: begin
				if (e_corner == 2'd2) begin
					push_cmd.base = marker_q;
					push_cmd.offs = '0;
					push_cmd.part = PART_MARKER;
					n_corner      = 2'd0;
				end else if (e_corner == 2'd0) begin
					push_cmd.base = e_row_base;
					n_corner      = 2'd1;
				end else begin
					push_cmd.base = e_row_base;
					push_cmd.offs = j_ext + s1;
					n_corner      = 2'd0;
					if (e_slice < slice_q) begin
						n_slice = slice_inc[SW-1:0];
					end else begin
						n_slice    = '0;
						n_row_base = e_row_base + s1;
						if (stack_inc3 < (TW + 2)'(stack_q)) begin
							n_stack  = e_stack + TW'(1);
							n_corner = 2'd2;
						end else begin
							n_stack = '0;
							n_phase = PART_SOUTH;
						end
					end
				end
			end
			PART_SOUTH: begin
				push_cmd.base = e_row_base;
				if (e_corner == 2'd1)
					push_cmd.offs = j_ext + IDX_W'(1);
				else if (e_corner == 2'd2)
					push_cmd.offs = j_ext + s1;
				if (e_corner < 2'd2) begin
					n_corner = e_corner + 2'd1;
				end else if (slice_inc < (SW + 1)'(slice_q)) begin
					n_corner = 2'd0;
					n_slice  = slice_inc[SW-1:0];
				end else begin
					// final index of the sphere: walk begins again
					push_cmd.last = 1'b1;
					n_phase    = PART_NORTH;
					n_stack    = '0;
					n_slice    = '0;
					n_corner   = 2'd0;
					n_row_base = s1;
				end
			end
			default: begin
				// north pole fan
				if (e_corner == 2'd1)
					push_cmd.offs = j_ext + s1;
				else if (e_corner == 2'd2)
					push_cmd.offs = j_ext + s1 + IDX_W'(1);
				if (e_corner < 2'd2) begin
					n_corner = e_corner + 2'd1;
				end else begin
					n_corner = 2'd0;
					if (slice_inc < (SW + 1)'(slice_q)) begin
						n_slice = slice_inc[SW-1:0];
					end else begin
						n_slice    = '0;
						n_stack    = '0;
						n_row_base = s1;
						n_phase    = (stack_q > TW'(2)) ? PART_BODY : PART_SOUTH;
					end
				end
			end
		endcase
	end

	// settings and marker value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_q  <= SW'(SLICE_RESET);
			stack_q  <= TW'(STACK_RESET);
			marker_q <= IDX_W'((STACK_RESET + 1) * (SLICE_RESET + 1));
		end else begin
			slice_q  <= new_slice;
			stack_q  <= new_stack;
			marker_q <= IDX_W'(((TW + SW + 2)'(stack_q) + (TW + SW + 2)'(1)) *
				((TW + SW + 2)'(slice_q) + (TW + SW + 2)'(1)));
		end
	end

	// walk counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PART_NORTH;
			stack_cnt_q <= '0;
			slice_cnt_q <= '0;
			corner_q    <= 2'd0;
			row_base_q  <= IDX_W'(SLICE_RESET + 1);
		end else if (cfg_wr_en) begin
			phase_q     <= PART_NORTH;
			stack_cnt_q <= '0;
			slice_cnt_q <= '0;
			corner_q    <= 2'd0;
			row_base_q  <= IDX_W'(new_slice) + IDX_W'(1);
		end else if (take) begin
			phase_q     <= n_phase;
			stack_cnt_q <= n_stack;
			slice_cnt_q <= n_slice;
			corner_q    <= n_corner;
			row_base_q  <= n_row_base;
		end
	end

endmodule

[design/smig_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smig_queue
// Short command queue that lets the sequencer and the output stage stall
// independently.
// ----------------------------------------------------------------------------
module smig_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  smig_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output smig_pkg::cmd_t pop_cmd
);
	import smig_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign push_ready = (count_q != CW'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

[design/smig_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smig_back
// Output stage: forms each index from its command and holds it in the
// output register until the transfer.
// ----------------------------------------------------------------------------
module smig_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  smig_pkg::cmd_t pop_cmd,
	smig_out_if.source     out_ch
);
	import smig_pkg::*;

	logic  valid_q;
	idx_t  index_q;
	part_t part_q;
	logic  last_q;

	assign pop_ready           = !valid_q || out_ch.ready;
	assign out_ch.valid        = valid_q;
	assign out_ch.vertex_index = index_q;
	assign out_ch.mesh_part    = part_q;
	assign out_ch.last         = last_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (pop_ready)
			valid_q <= pop_valid;
	end

	// payload: index add
	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid) begin
			index_q <= pop_cmd.base + pop_cmd.offs;
			part_q  <= pop_cmd.part;
			last_q  <= pop_cmd.last;
		end
	end

endmodule

[design/sphere_mesh_index_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_mesh_index_generator
// Index list generator for a latitude/longitude sphere mesh.
// ----------------------------------------------------------------------------
// Each accepted request on in_ch yields one index on out_ch: north pole
// triangles, body strips separated by restart markers, then south pole
// triangles, with last set on the final index, after which the list starts
// over. While out_ch is not stalled, the block takes one request per cycle and
// delivers one index per cycle; a taken request passes through the command
// queue and then the output register before its result is offered on out_ch.
// A two-entry command queue sits between sequencer and output stage, so after
// out_ch stalls requests keep being taken until the queue is full: one more
// transfer when the stream was flowing back to back, two when the queue was
// empty. Writing slice_count (index 0) or stack_count (index 1) clamps the
// value to its range and restarts the list; write only while no results are
// outstanding.
// ----------------------------------------------------------------------------
module sphere_mesh_index_generator #(
	parameter int MAX_SLICES = 256,
	parameter int MAX_STACKS = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [smig_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [smig_pkg::CFG_W-1:0]     cfg_data,
	smig_in_if.sink                       in_ch,
	smig_out_if.source                    out_ch
);
	import smig_pkg::*;

	logic push_valid, push_ready;
	cmd_t push_cmd;
	logic pop_valid, pop_ready;
	cmd_t pop_cmd;

	// sequencer
	smig_front #(
		.MAX_SLICES(MAX_SLICES),
		.MAX_STACKS(MAX_STACKS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.push_ready(push_ready),
		.push_valid(push_valid),
		.push_cmd  (push_cmd)
	);

	// command queue
	smig_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd)
	);

	// output stage
	smig_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_cmd  (pop_cmd),
		.out_ch   (out_ch)
	);

endmodule

[design/smig_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smig_checker
// Port-level checks of the sphere mesh index generator, bound to the top.
// ----------------------------------------------------------------------------
module smig_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [smig_pkg::IDX_W-1:0] out_index,
	input logic [1:0]                 out_part,
	input logic                       out_last
);
	import smig_pkg::*;

	logic [2:0] outstanding_q;
	logic       in_xfer, out_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// requests taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			outstanding_q <= '0;
		else if (in_xfer && !out_xfer)
			outstanding_q <= outstanding_q + 3'd1;
		else if (out_xfer && !in_xfer)
			outstanding_q <= outstanding_q - 3'd1;
	end

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_index) &&
		$stable(out_part) && $stable(out_last))
		else $error("stalled result changed");

	// no result without a request behind it
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> outstanding_q != 3'd0)
		else $error("result without a pending request");

	// queue plus output register bound the requests in flight
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= 3'(QUEUE_DEPTH + 1))
		else $error("too many requests in flight");

	// the closing index belongs to the south pole
	a_last_south: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> out_part == PART_SOUTH)
		else $error("last flag outside the south pole");

endmodule

bind sphere_mesh_index_generator smig_checker u_smig_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_ch.valid),
	.in_ready (in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_index(out_ch.vertex_index),
	.out_part (out_ch.mesh_part),
	.out_last (out_ch.last)
);
